// File: rtl/core/m6502_pkg.sv
// m6502_pkg: item types, opcode codes and register map for the 6502 subset executor
// no dependencies; imported by mos6502_subset_executor
`default_nettype none

package m6502_pkg;

  // supported opcodes
  localparam logic [7:0] OP_JMP_ABS  = 8'h4C;
  localparam logic [7:0] OP_BNE      = 8'hD0;
  localparam logic [7:0] OP_CPX_IMM  = 8'hE0;
  localparam logic [7:0] OP_CPY_IMM  = 8'hC0;
  localparam logic [7:0] OP_LDA_IMM  = 8'hA9;
  localparam logic [7:0] OP_LDX_IMM  = 8'hA2;
  localparam logic [7:0] OP_LDY_IMM  = 8'hA0;
  localparam logic [7:0] OP_LDA_ZP   = 8'hA5;
  localparam logic [7:0] OP_STA_ZP   = 8'h85;
  localparam logic [7:0] OP_STX_ZP   = 8'h86;
  localparam logic [7:0] OP_STY_ZP   = 8'h84;
  localparam logic [7:0] OP_INC_ZP   = 8'hE6;
  localparam logic [7:0] OP_STA_ZPX  = 8'h95;
  localparam logic [7:0] OP_INX      = 8'hE8;
  localparam logic [7:0] OP_INY      = 8'hC8;
  localparam logic [7:0] OP_DEY      = 8'h88;
  localparam logic [7:0] OP_NOP      = 8'hEA;

  // status bit positions
  localparam int unsigned FLAG_N_BIT = 7;
  localparam int unsigned FLAG_Z_BIT = 1;
  localparam int unsigned FLAG_C_BIT = 0;

  // configuration register map
  localparam int unsigned CFG_ADDR_W     = 3;
  localparam logic        REG_START_ADDR = 1'b0;
  localparam logic [15:0] START_ADDR_RST = 16'hF000;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] operand_low;
    logic [7:0] operand_high;
    logic [7:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        mem_write;
    logic [7:0]  mem_addr;
    logic [7:0]  write_data;
    logic [7:0]  status_flags;
    logic [7:0]  accumulator;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [2:0]  cycle_count;
    logic        unknown_opcode;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/mos6502_subset_executor.sv
// mos6502_subset_executor: one 6502 instruction per item against PC/A/X/Y/status
// depends on m6502_pkg (item types, opcode codes, register map)
//
//  channel | direction | handshake                   | payload
//  in_     | input     | in_valid / in_ready         | m6502_pkg::in_item_t
//  out_    | output    | out_valid / out_ready       | m6502_pkg::out_item_t
//  cfg_    | apb write | cfg_psel/penable/pwrite     | start_address at byte 0
//
// an accepted item is held in the input register, then is decoded and executed and
// lands in the result register; one item a cycle unless the output stalls
// the single execute stage between the two registers sets the rate
// the architectural registers update when an item moves into the result register
// rst_n (synchronous) loads PC with 0xF000 and clears A, X, Y and status
// a full result register that is not taken stalls the execute stage and the input
`default_nettype none

module mos6502_subset_executor (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  m6502_pkg::in_item_t                   in_item,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output m6502_pkg::out_item_t                  out_item,
  input  wire                                   cfg_psel,
  input  wire                                   cfg_penable,
  input  wire                                   cfg_pwrite,
  input  wire [m6502_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  wire [31:0]                            cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);
  import m6502_pkg::*;

  logic        in_v_r;
  in_item_t    in_r;
  logic        out_v_r;
  out_item_t   out_r;
  logic [15:0] start_addr_r;
  logic [15:0] pc_r, pc_nxt;
  logic [7:0]  acc_r, acc_nxt;
  logic [7:0]  x_r, x_nxt;
  logic [7:0]  y_r, y_nxt;
  logic [7:0]  flags_r, flags_nxt;
  out_item_t   res_nxt;
  logic        adv;
  logic        cfg_wr;
  logic [7:0]  nz_val;
  logic        set_nz;
  logic [15:0] pc_plus1, pc_plus2, br_target;
  logic [7:0]  cmp_reg;
  logic [8:0]  cmp_diff;
  logic        is_cmp;

  // handshake: execute stage advances when the result register is free or drained
  assign adv      = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;
  assign out_valid = out_v_r;
  assign out_item  = out_r;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_ADDR_W-1] == REG_START_ADDR) begin
      cfg_prdata = {16'd0, start_addr_r};
    end
  end

  // pc arithmetic
  assign pc_plus1  = pc_r + 16'd1;
  assign pc_plus2  = pc_r + 16'd2;
  assign br_target = pc_plus2 + {{8{in_r.operand_low[7]}}, in_r.operand_low};
  assign cmp_reg   = (in_r.opcode == OP_CPX_IMM) ? x_r : y_r;
  assign cmp_diff  = {1'b0, cmp_reg} - {1'b0, in_r.operand_low};

  // decode and execute
  always_comb begin
    pc_nxt  = pc_r;
    acc_nxt = acc_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    nz_val  = 8'd0;
    set_nz  = 1'b0;
    is_cmp  = 1'b0;
    res_nxt = '0;
    case (in_r.opcode)
      OP_JMP_ABS: begin
        pc_nxt = {in_r.operand_high, in_r.operand_low};
        res_nxt.cycle_count = 3'd3;
      end
      OP_BNE: begin
        pc_nxt = flags_r[FLAG_Z_BIT] ? pc_plus2 : br_target;
        res_nxt.cycle_count = 3'd2;
      end
      OP_CPX_IMM, OP_CPY_IMM: begin
        is_cmp = 1'b1;
        set_nz = 1'b1;
        nz_val = cmp_diff[7:0];
        pc_nxt = pc_plus2;
        res_nxt.cycle_count = 3'd2;
      end
      OP_LDA_IMM: begin
        acc_nxt = in_r.operand_low;
        set_nz  = 1'b1;
        nz_val  = in_r.operand_low;
        pc_nxt  = pc_plus2;
        res_nxt.cycle_count = 3'd2;
      end
      OP_LDX_IMM: begin
        x_nxt  = in_r.operand_low;
        set_nz = 1'b1;
        nz_val = in_r.operand_low;
        pc_nxt = pc_plus2;
        res_nxt.cycle_count = 3'd2;
      end
      OP_LDY_IMM: begin
        y_nxt  = in_r.operand_low;
        set_nz = 1'b1;
        nz_val = in_r.operand_low;
        pc_nxt = pc_plus2;
        res_nxt.cycle_count = 3'd2;
      end
      OP_LDA_ZP: begin
        acc_nxt = in_r.read_data;
        set_nz  = 1'b1;
        nz_val  = in_r.read_data;
        pc_nxt  = pc_plus2;
        res_nxt.cycle_count = 3'd3;
      end
      OP_STA_ZP: begin
        res_nxt.mem_write  = 1'b1;
        res_nxt.mem_addr   = in_r.operand_low;
        res_nxt.write_data = acc_r;
        pc_nxt = pc_plus2;
        res_nxt.cycle_count = 3'd3;
      end
      OP_STX_ZP: begin
        res_nxt.mem_write  = 1'b1;
        res_nxt.mem_addr   = in_r.operand_low;
        res_nxt.write_data = x_r;
        pc_nxt = pc_plus2;
        res_nxt.cycle_count = 3'd3;
      end
      OP_STY_ZP: begin
        res_nxt.mem_write  = 1'b1;
        res_nxt.mem_addr   = in_r.operand_low;
        res_nxt.write_data = y_r;
        pc_nxt = pc_plus2;
        res_nxt.cycle_count = 3'd3;
      end
      OP_STA_ZPX: begin
        // indexed address wraps within page zero
        res_nxt.mem_write  = 1'b1;
        res_nxt.mem_addr   = in_r.operand_low + x_r;
        res_nxt.write_data = acc_r;
        pc_nxt = pc_plus2;
        res_nxt.cycle_count = 3'd4;
      end
      OP_INC_ZP: begin
        res_nxt.mem_write  = 1'b1;
        res_nxt.mem_addr   = in_r.operand_low;
        res_nxt.write_data = in_r.read_data + 8'd1;
        set_nz = 1'b1;
        nz_val = in_r.read_data + 8'd1;
        pc_nxt = pc_plus2;
        res_nxt.cycle_count = 3'd5;
      end
      OP_INX: begin
        x_nxt  = x_r + 8'd1;
        set_nz = 1'b1;
        nz_val = x_r + 8'd1;
        pc_nxt = pc_plus1;
        res_nxt.cycle_count = 3'd2;
      end
      OP_INY: begin
        y_nxt  = y_r + 8'd1;
        set_nz = 1'b1;
        nz_val = y_r + 8'd1;
        pc_nxt = pc_plus1;
        res_nxt.cycle_count = 3'd2;
      end
      OP_DEY: begin
        y_nxt  = y_r - 8'd1;
        set_nz = 1'b1;
        nz_val = y_r - 8'd1;
        pc_nxt = pc_plus1;
        res_nxt.cycle_count = 3'd2;
      end
      OP_NOP: begin
        pc_nxt = pc_plus1;
        res_nxt.cycle_count = 3'd2;
      end
      default: begin
        res_nxt.unknown_opcode = 1'b1;
      end
    endcase

    // status update: only N, Z and C ever change
    flags_nxt = flags_r;
    if (set_nz) begin
      flags_nxt[FLAG_N_BIT] = nz_val[7];
      flags_nxt[FLAG_Z_BIT] = (nz_val == 8'd0);
    end
    if (is_cmp) begin
      flags_nxt[FLAG_C_BIT] = !cmp_diff[8];
    end

    res_nxt.next_pc      = pc_nxt;
    res_nxt.status_flags = flags_nxt;
    res_nxt.accumulator  = acc_nxt;
    res_nxt.index_x      = x_nxt;
    res_nxt.index_y      = y_nxt;
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      start_addr_r <= START_ADDR_RST;
      pc_r         <= START_ADDR_RST;
      acc_r        <= 8'd0;
      x_r          <= 8'd0;
      y_r          <= 8'd0;
      flags_r      <= 8'd0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
        pc_r    <= pc_nxt;
        acc_r   <= acc_nxt;
        x_r     <= x_nxt;
        y_r     <= y_nxt;
        flags_r <= flags_nxt;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_wr && cfg_paddr[CFG_ADDR_W-1] == REG_START_ADDR) begin
        start_addr_r <= cfg_pwdata[15:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_item;
    end
    if (adv) begin
      out_r <= res_nxt;
    end
  end

  // checks
  a_pc_follows_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_r.next_pc == pc_r))
    else $error("pc does not match reported next_pc");

  a_unknown_keeps_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res_nxt.unknown_opcode) |=> (pc_r == $past(pc_r) && acc_r == $past(acc_r)))
    else $error("unknown opcode changed state");

  a_no_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.mem_write) |-> (out_r.mem_addr == 8'd0 && out_r.write_data == 8'd0))
    else $error("store fields set without a store");

  a_unknown_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.unknown_opcode) |-> (!out_r.mem_write && out_r.cycle_count == 3'd0))
    else $error("unknown opcode reported a store or cycles");

  a_flags_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r[6:2] == 5'd0)
    else $error("reserved status bits changed");

endmodule

`default_nettype wire
